/* rtl/cbb_pkg.sv */
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants for the circuit breaker with backoff.
// ----------------------------------------------------------------------------
package cbb_pkg;

   localparam int THRESH_W = 16;
   localparam int MS_W     = 20;
   localparam int NS_W     = 40;
   localparam int TIME_W   = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [NS_W-1:0] NS_PER_MS = NS_W'(1000 * 1000);

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(8);
   localparam logic [MS_W-1:0]     FIRST_RESET  = MS_W'(1000);
   localparam logic [MS_W-1:0]     MAX_RESET    = MS_W'(30000);

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_MS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MS    = CSR_IDX_W'(2);

   localparam logic MODE_QUERY    = 1'b0;
   localparam logic MODE_CALL_END = 1'b1;

   localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;
   localparam logic [1:0] OUTCOME_NEUTRAL = 2'd1;

   typedef enum logic [1:0] {
      ST_CLOSED = 2'd0,
      ST_OPEN   = 2'd1,
      ST_HALF   = 2'd2
   } state_type;

   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic [MS_W-1:0]     first_ms;
      logic [MS_W-1:0]     max_ms;
      logic [NS_W-1:0]     first_ns;
      logic [NS_W-1:0]     max_ns;
   } cfg_type;

endpackage

/* rtl/cbb_req_if.sv */
// ----------------------------------------------------------------------------
// cbb_req_if
// Request channel: permission queries and call-end reports.
// ----------------------------------------------------------------------------
interface cbb_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [1:0]  outcome;
   logic [63:0] now_ns;

   modport source (output valid, output mode, output outcome, output now_ns,
                   input ready);
   modport sink   (input valid, input mode, input outcome, input now_ns,
                   output ready);
endinterface

/* rtl/cbb_rsp_if.sv */
// ----------------------------------------------------------------------------
// cbb_rsp_if
// Response channel: permission decision and breaker state.
// ----------------------------------------------------------------------------
interface cbb_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [1:0] breaker_state;

   modport source (output valid, output allowed, output breaker_state,
                   input ready);
   modport sink   (input valid, input allowed, input breaker_state,
                   output ready);
endinterface

/* rtl/cbb_csr.sv */
// ----------------------------------------------------------------------------
// cbb_csr
// Configuration registers with precomputed window lengths in nanoseconds.
// ----------------------------------------------------------------------------
module cbb_csr
   import cbb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type              cfg
);

   logic [THRESH_W-1:0] threshold_ff;
   logic [MS_W-1:0]     first_ms_ff;
   logic [MS_W-1:0]     max_ms_ff;
   logic [NS_W-1:0]     first_ns_ff;
   logic [NS_W-1:0]     max_ns_ff;
   logic [NS_W-1:0]     first_ns_in;
   logic [NS_W-1:0]     max_ns_in;

   assign first_ns_in = NS_W'(first_ms_ff) * NS_PER_MS;
   assign max_ns_in   = NS_W'(max_ms_ff) * NS_PER_MS;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         first_ms_ff  <= FIRST_RESET;
         max_ms_ff    <= MAX_RESET;
         first_ns_ff  <= NS_W'(FIRST_RESET) * NS_PER_MS;
         max_ns_ff    <= NS_W'(MAX_RESET) * NS_PER_MS;
      end else begin
         first_ns_ff <= first_ns_in;
         max_ns_ff   <= max_ns_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
               CSR_FIRST_MS:  first_ms_ff  <= csr_wdata[MS_W-1:0];
               CSR_MAX_MS:    max_ms_ff    <= csr_wdata[MS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.first_ms  = first_ms_ff;
   assign cfg.max_ms    = max_ms_ff;
   assign cfg.first_ns  = first_ns_ff;
   assign cfg.max_ns    = max_ns_ff;

endmodule

/* rtl/cbb_core.sv */
// ----------------------------------------------------------------------------
// cbb_core
// Breaker state, failure counter, backoff window and open deadline.
// ----------------------------------------------------------------------------
module cbb_core
   import cbb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              mode,
   input  logic [1:0]        outcome,
   input  logic [TIME_W-1:0] now_ns,
   input  cfg_type           cfg,
   output logic              allowed,
   output state_type         state_next
);

   state_type           state_ff,    state_in;
   logic                probe_ff,    probe_in;
   logic [THRESH_W-1:0] count_ff,    count_in;
   logic [MS_W-1:0]     win_ms_ff,   win_ms_in;
   logic [NS_W-1:0]     win_ns_ff,   win_ns_in;
   logic [TIME_W-1:0]   deadline_ff, deadline_in;

   logic [MS_W:0]       win_dbl;
   logic [MS_W-1:0]     trip_ms;
   logic [NS_W-1:0]     trip_ns;
   logic [THRESH_W-1:0] count_inc;
   logic                expired;

   assign win_dbl   = {win_ms_ff, 1'b0};
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign expired   = now_ns >= deadline_ff;

   // backoff window for a trip
   always_comb begin
      if (win_ms_ff == '0) begin
         trip_ms = cfg.first_ms;
         trip_ns = cfg.first_ns;
      end else if (win_dbl < {1'b0, cfg.max_ms}) begin
         trip_ms = win_dbl[MS_W-1:0];
         trip_ns = {win_ns_ff[NS_W-2:0], 1'b0};
      end else begin
         trip_ms = cfg.max_ms;
         trip_ns = cfg.max_ns;
      end
   end

   // next state
   always_comb begin
      logic trip;
      trip        = 1'b0;
      state_in    = state_ff;
      probe_in    = probe_ff;
      count_in    = count_ff;
      win_ms_in   = win_ms_ff;
      win_ns_in   = win_ns_ff;
      deadline_in = deadline_ff;
      if (mode == MODE_QUERY) begin
         unique case (state_ff)
            ST_OPEN: begin
               if (expired) begin
                  state_in = ST_HALF;
                  probe_in = 1'b1;
               end
            end
            ST_HALF: probe_in = 1'b1;
            default: ;
         endcase
      end else begin
         probe_in = 1'b0;
         if (outcome == OUTCOME_SUCCESS) begin
            count_in = '0;
            if (state_ff == ST_HALF) begin
               state_in  = ST_CLOSED;
               win_ms_in = '0;
               win_ns_in = '0;
            end
         end else if (outcome != OUTCOME_NEUTRAL) begin
            unique case (state_ff)
               ST_CLOSED: begin
                  count_in = count_inc;
                  trip     = count_inc >= cfg.threshold;
               end
               ST_HALF: trip = 1'b1;
               default: ;
            endcase
         end
      end
      if (trip) begin
         state_in    = ST_OPEN;
         win_ms_in   = trip_ms;
         win_ns_in   = trip_ns;
         deadline_in = now_ns + TIME_W'(trip_ns);
         count_in    = '0;
         probe_in    = 1'b0;
      end
   end

   // outputs
   always_comb begin
      allowed = 1'b0;
      if (mode == MODE_QUERY) begin
         unique case (state_ff)
            ST_OPEN: allowed = expired;
            ST_HALF: allowed = !probe_ff;
            default: allowed = 1'b1;
         endcase
      end
   end

   assign state_next = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLOSED;
         probe_ff    <= 1'b0;
         count_ff    <= '0;
         win_ms_ff   <= '0;
         win_ns_ff   <= '0;
         deadline_ff <= '0;
      end else if (step) begin
         state_ff    <= state_in;
         probe_ff    <= probe_in;
         count_ff    <= count_in;
         win_ms_ff   <= win_ms_in;
         win_ns_ff   <= win_ns_in;
         deadline_ff <= deadline_in;
      end
   end

   a_probe_half: assert property (@(posedge clock) disable iff (reset)
      probe_ff |-> state_ff == ST_HALF)
      else $error("probe in flight outside half-open");

   a_count_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLOSED |-> count_ff == '0)
      else $error("failure count nonzero outside closed");

   a_query_closed: assert property (@(posedge clock) disable iff (reset)
      step && mode == MODE_QUERY && state_ff == ST_CLOSED |=> state_ff == ST_CLOSED)
      else $error("query left closed state");

   a_window_zero: assert property (@(posedge clock) disable iff (reset)
      win_ms_ff == '0 |-> win_ns_ff == '0)
      else $error("window lengths disagree");

endmodule

/* rtl/circuit_breaker_backoff.sv */
// ----------------------------------------------------------------------------
// circuit_breaker_backoff
// Three-state circuit breaker with exponential backoff of the open window.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    mode, outcome, now_ns
//   rsp      out  valid / ready    allowed, breaker_state
//   csr      in   csr_write        csr_index, csr_wdata
//
// one item per cycle sustained while rsp.ready stays high
// input register, then state update into the output register
// window lengths in ns are precomputed into registers from the registered csr ms values
// reset clears breaker state and loads default configuration
// a stalled response holds the pipeline; req.ready drops only when both stages are full
// ----------------------------------------------------------------------------
module circuit_breaker_backoff
   import cbb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   cbb_req_if.sink              req,
   cbb_rsp_if.source            rsp,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic              in_valid_ff;
   logic              in_mode_ff;
   logic [1:0]        in_outcome_ff;
   logic [TIME_W-1:0] in_now_ff;

   logic              out_valid_ff;
   logic              out_allowed_ff;
   state_type         out_state_ff;

   logic              advance;
   logic              step;
   logic              allowed;
   state_type         state_next;

   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   cbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbb_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .mode       (in_mode_ff),
      .outcome    (in_outcome_ff),
      .now_ns     (in_now_ff),
      .cfg        (cfg),
      .allowed    (allowed),
      .state_next (state_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_mode_ff    <= req.mode;
         in_outcome_ff <= req.outcome;
         in_now_ff     <= req.now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_allowed_ff <= allowed;
         out_state_ff   <= state_next;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.allowed       = out_allowed_ff;
   assign rsp.breaker_state = out_state_ff;

endmodule

/* tb/sv/tb_circuit_breaker_backoff.sv */
// ----------------------------------------------------------------------------
// tb_circuit_breaker_backoff
// Self-checking testbench for the circuit breaker with exponential backoff.
// Directed tests cover the reset configuration, window doubling and its
// ceiling, zero threshold and zero window, an uncapped first window, deadline
// wraparound and input stall under a held-off response channel. They are
// followed by phases of random query and call-end traffic under several
// configurations. A local model of the breaker predicts every response, and
// the responses are compared in order.
// ----------------------------------------------------------------------------
module tb_circuit_breaker_backoff
   import cbb_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OUTCOME_FAILURE = 2'd2;
   localparam logic [1:0] OUTCOME_UNUSED  = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 150;

   typedef struct packed {
      logic      allowed;
      state_type state;
   } breaker_decision_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   cbb_req_if req_ch ();
   cbb_rsp_if rsp_ch ();

   circuit_breaker_backoff i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the breaker
   logic [THRESH_W-1:0] cfg_threshold;
   logic [MS_W-1:0]     cfg_first_ms;
   logic [MS_W-1:0]     cfg_max_ms;
   state_type           brk_state;
   logic                brk_probe;
   logic [THRESH_W-1:0] brk_fail_cnt;
   logic [MS_W-1:0]     brk_window_ms;
   logic [63:0]         brk_deadline;

   breaker_decision_type expected_decisions[$];
   int unsigned          error_count;
   int unsigned          rsp_hold;
   logic [63:0]          sim_now;
   int unsigned          gap_free_left;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic void breaker_trip(input logic [63:0] now);
      logic [MS_W:0] doubled;
      doubled = {1'b0, brk_window_ms} << 1;
      brk_state = ST_OPEN;
      if (brk_window_ms == '0) begin
         brk_window_ms = cfg_first_ms;
      end else if (doubled < {1'b0, cfg_max_ms}) begin
         brk_window_ms = doubled[MS_W-1:0];
      end else begin
         brk_window_ms = cfg_max_ms;
      end
      brk_deadline = now + 64'(brk_window_ms) * 64'(NS_PER_MS);
      brk_fail_cnt = '0;
      brk_probe = 1'b0;
   endfunction

   function automatic breaker_decision_type breaker_predict(input logic mode,
         input logic [1:0] outcome, input logic [63:0] now);
      breaker_decision_type d;
      d.allowed = 1'b0;
      if (mode == MODE_QUERY) begin
         if (brk_state == ST_OPEN) begin
            if (now >= brk_deadline) begin
               brk_state = ST_HALF;
               brk_probe = 1'b1;
               d.allowed = 1'b1;
            end
         end else if (brk_state == ST_HALF) begin
            if (!brk_probe) begin
               brk_probe = 1'b1;
               d.allowed = 1'b1;
            end
         end else begin
            d.allowed = 1'b1;
         end
      end else begin
         brk_probe = 1'b0;
         if (outcome == OUTCOME_SUCCESS) begin
            brk_fail_cnt = '0;
            if (brk_state == ST_HALF) begin
               brk_state = ST_CLOSED;
               brk_window_ms = '0;
            end
         end else if (outcome != OUTCOME_NEUTRAL) begin
            if (brk_state == ST_CLOSED) begin
               if (brk_fail_cnt != '1)
                  brk_fail_cnt++;
               if (brk_fail_cnt >= cfg_threshold)
                  breaker_trip(now);
            end else if (brk_state == ST_HALF) begin
               breaker_trip(now);
            end
         end
      end
      d.state = brk_state;
      return d;
   endfunction

   function automatic int unsigned next_gap();
      int unsigned r;
      if (gap_free_left > 0) begin
         gap_free_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         gap_free_left = $urandom_range(20, 80);
         return 0;
      end else if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] next_now();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)
         sim_now = {$urandom, $urandom};
      else if (r < 5)
         sim_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3000000));
      else if (r < 80)
         sim_now = sim_now + 64'($urandom_range(0, 1500000));
      else
         sim_now = sim_now + 64'($urandom_range(0, 12000000));
      return sim_now;
   endfunction

   function automatic logic [1:0] pick_outcome();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35)
         return OUTCOME_SUCCESS;
      else if (r < 50)
         return OUTCOME_NEUTRAL;
      else if (r < 90)
         return OUTCOME_FAILURE;
      return OUTCOME_UNUSED;
   endfunction

   task automatic offer_item(input logic mode, input logic [1:0] outcome,
         input logic [63:0] now, input int unsigned gap);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= mode;
      req_ch.outcome <= outcome;
      req_ch.now_ns  <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_decisions.push_back(breaker_predict(mode, outcome, now));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic set_config(input logic [THRESH_W-1:0] thr,
         input logic [MS_W-1:0] first_ms, input logic [MS_W-1:0] max_ms);
      wait_drained();
      write_reg(CSR_THRESHOLD, CSR_DAT_W'(thr));
      write_reg(CSR_FIRST_MS, first_ms);
      write_reg(CSR_MAX_MS, max_ms);
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_threshold = thr;
      cfg_first_ms  = first_ms;
      cfg_max_ms    = max_ms;
      repeat (3) @(negedge clock);
   endtask

   // reset configuration: threshold 8, first window 1000 ms
   task automatic test_reset_config();
      logic [63:0] t;
      t = 64'd1000;
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      repeat (8) offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, next_gap());
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t + 64'd999_999_999, 0);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t + 64'd1_000_000_000, next_gap());
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t + 64'd1_000_000_001, 0);
      offer_item(MODE_CALL_END, OUTCOME_SUCCESS, t + 64'd1_000_000_002, 0);
   endtask

   // doubling, ceiling, neutral, unused outcome, failure while open
   task automatic test_backoff_doubling();
      logic [63:0] t;
      set_config(16'd1, 20'd3, 20'd10);
      t = 64'd5_000_000_000;
      offer_item(MODE_CALL_END, OUTCOME_NEUTRAL, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t + 64'd1, next_gap());
      t = t + 64'd3_000_000;
      offer_item(MODE_QUERY, OUTCOME_UNUSED, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_NEUTRAL, t, 0);
      offer_item(MODE_QUERY, OUTCOME_NEUTRAL, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, next_gap());
      t = t + 64'd6_000_000;
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_UNUSED, t, 0);
      t = t + 64'd10_000_000;
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_SUCCESS, t, 0);
   endtask

   // zero threshold, zero first window, first window above the ceiling
   task automatic test_zero_and_uncapped();
      logic [63:0] t;
      set_config(16'd0, 20'd0, 20'd0);
      t = 64'd77;
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, 0);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, 0);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_SUCCESS, t, 0);
      set_config(16'd2, 20'd1000000, 20'd5);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_UNUSED, t, 0);
      t = t + 64'd1_000_000_000_000;
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, t, 0);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, t + 64'd5_000_000, 0);
   endtask

   // deadline sum wraps past the top of the time range
   task automatic test_deadline_wrap();
      set_config(16'd1, 20'd1000000, 20'd1000000);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, 64'd0, 0);
      offer_item(MODE_CALL_END, OUTCOME_FAILURE, 64'hFFFF_FFFF_FFFF_FFF0, 0);
      offer_item(MODE_QUERY, OUTCOME_SUCCESS, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      offer_item(MODE_CALL_END, OUTCOME_SUCCESS, 64'hFFFF_FFFF_FFFF_FFFF, 0);
   endtask

   // response side held off while items keep coming
   task automatic test_input_stall();
      int i;
      wait_drained();
      rsp_hold = HOLD_CYCLES;
      for (i = 0; i < 30; i++)
         offer_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    next_now(), 0);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 75) begin
            offer_item(MODE_QUERY, 2'($urandom_range(0, 3)), next_now(),
                       next_gap());
            offer_item(MODE_CALL_END, pick_outcome(), next_now(), next_gap());
            sent += 2;
         end else begin
            offer_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       next_now(), next_gap());
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      set_config(16'd2, 20'd1, 20'd6);
      run_random(150);
      set_config(16'd0, 20'd0, 20'd3);
      run_random(150);
      set_config(THRESH_W'($urandom_range(0, 5)), MS_W'($urandom_range(0, 3)),
                 MS_W'($urandom_range(0, 10)));
      run_random(150);
      set_config(16'd65535, 20'd1000000, 20'd1000000);
      run_random(40);
      set_config(16'd1, 20'd1000000, 20'd1000000);
      run_random(110);
      set_config(16'd1, 20'd5, 20'd0);
      run_random(150);
      set_config(THRESH_W'($urandom_range(0, 5)), MS_W'($urandom_range(0, 3)),
                 MS_W'($urandom_range(0, 10)));
      run_random(150);
   endtask

   // response ready with random stalls and free stretches
   initial begin
      int unsigned stall_left;
      int unsigned free_left;
      int unsigned r;
      stall_left = 0;
      free_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (free_left > 0) begin
               free_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 5)
                  free_left = $urandom_range(30, 150);
               else if (r < 20)
                  stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                            : $urandom_range(8, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      breaker_decision_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_decisions.size() == 0) begin
            report_error("response item with nothing expected");
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_ch.allowed !== want.allowed)
               report_error($sformatf("allowed got %0b expected %0b",
                                      rsp_ch.allowed, want.allowed));
            if (rsp_ch.breaker_state !== want.state)
               report_error($sformatf("breaker_state got %0d expected %0d",
                                      rsp_ch.breaker_state, want.state));
         end
      end
   end

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[circuit_breaker_backoff] ERROR");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_QUERY;
      req_ch.outcome = OUTCOME_SUCCESS;
      req_ch.now_ns  = '0;
      rsp_ch.ready   = 1'b0;
      error_count    = 0;
      rsp_hold       = 0;
      gap_free_left  = 0;
      sim_now        = 64'd10_000_000_000;
      cfg_threshold  = THRESH_RESET;
      cfg_first_ms   = FIRST_RESET;
      cfg_max_ms     = MAX_RESET;
      brk_state      = ST_CLOSED;
      brk_probe      = 1'b0;
      brk_fail_cnt   = '0;
      brk_window_ms  = '0;
      brk_deadline   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_reset_config();
      test_backoff_doubling();
      test_zero_and_uncapped();
      test_deadline_wrap();
      test_input_stall();
      test_random_traffic();

      wait_drained();
      if (error_count == 0)
         $display("[circuit_breaker_backoff] OK");
      else
         $display("[circuit_breaker_backoff] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/cbb_pkg.sv
rtl/cbb_req_if.sv
rtl/cbb_rsp_if.sv
rtl/cbb_csr.sv
rtl/cbb_core.sv
rtl/circuit_breaker_backoff.sv
tb/sv/tb_circuit_breaker_backoff.sv
